>>> src/psr_pkg.sv
// psr_pkg: shared types and constants of the PI speed regulator
// holds the control word layout, sequencer step numbers and fixed-point constants
// no dependencies
package psr_pkg;

  // fixed widths of the number formats
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned LIM_W   = 15;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned KDEC_W  = 16;
  localparam int unsigned MAG_W   = 34;
  localparam int unsigned MUL_A_W = 35;
  localparam int unsigned MUL_B_W = GAIN_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W  = 4;

  // decay factors in Q0.16
  localparam logic [KDEC_W-1:0] K_DECAY_CLAMPED  = 16'd58982;
  localparam logic [KDEC_W-1:0] K_DECAY_DEADBAND = 16'd62259;

  // magnitude cap ahead of a decay multiply
  localparam logic [MAG_W-1:0] MAG_CAP = 34'h2_0000_0000;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DRIVE_LIMIT = 3'd2,
    REG_GOAL_LIMIT  = 3'd3,
    REG_DEADBAND    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_KP,
    MUL_KI,
    MUL_DECAY
  } mul_op_e;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_PROD_INTEG,
    SUM_INTEG,
    SUM_DECAY
  } sum_op_e;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_GOAL,
    JMP_SAT,
    JMP_NO_DECAY
  } jmp_e;

  // program step numbers
  localparam logic [STEP_W-1:0] ST_START  = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL_KP = 4'd1;
  localparam logic [STEP_W-1:0] ST_SUM    = 4'd2;
  localparam logic [STEP_W-1:0] ST_DRIVE  = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL_KI = 4'd4;
  localparam logic [STEP_W-1:0] ST_INTEG  = 4'd5;
  localparam logic [STEP_W-1:0] ST_DECAY  = 4'd6;
  localparam logic [STEP_W-1:0] ST_SCALE  = 4'd7;
  localparam logic [STEP_W-1:0] ST_LOAD_I = 4'd8;
  localparam logic [STEP_W-1:0] ST_CLAMP  = 4'd9;
  localparam logic [STEP_W-1:0] ST_GOAL   = 4'd10;

  // one control word of the program
  typedef struct packed {
    mul_op_e           mul_op;
    sum_op_e           sum_op;
    logic              ld_err;
    logic              eval_drive;
    logic              upd_integ;
    logic              set_goal;
    logic              emit;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
    logic              done;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    mul_op:     MUL_NONE,
    sum_op:     SUM_HOLD,
    ld_err:     1'b0,
    eval_drive: 1'b0,
    upd_integ:  1'b0,
    set_goal:   1'b0,
    emit:       1'b0,
    jmp:        JMP_NONE,
    target:     ST_START,
    done:       1'b0
  };

  // datapath flags the sequencer branches on
  typedef struct packed {
    logic is_goal;
    logic sat;
    logic no_decay;
  } status_t;

endpackage

>>> src/psr_sequencer.sv
// psr_sequencer: step counter and program table of the PI speed regulator
// issues one control word per cycle unless a full output stalls it, branches on datapath flags
// depends on psr_pkg
module psr_sequencer import psr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    out_full_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    busy_o
);

  // program table
  function automatic ctrl_t rom(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = CTRL_NOP;
    case (step)
      ST_START: begin
        c.ld_err = 1'b1;
        c.jmp    = JMP_GOAL;
        c.target = ST_GOAL;
      end
      ST_MUL_KP: c.mul_op = MUL_KP;
      ST_SUM:    c.sum_op = SUM_PROD_INTEG;
      ST_DRIVE: begin
        c.eval_drive = 1'b1;
        c.jmp        = JMP_SAT;
        c.target     = ST_LOAD_I;
      end
      ST_MUL_KI: c.mul_op = MUL_KI;
      ST_INTEG: begin
        c.sum_op = SUM_PROD_INTEG;
        c.jmp    = JMP_NO_DECAY;
        c.target = ST_CLAMP;
      end
      ST_DECAY: c.mul_op = MUL_DECAY;
      ST_SCALE: begin
        c.sum_op = SUM_DECAY;
        c.jmp    = JMP_ALWAYS;
        c.target = ST_CLAMP;
      end
      ST_LOAD_I: begin
        c.sum_op = SUM_INTEG;
        c.jmp    = JMP_ALWAYS;
        c.target = ST_DECAY;
      end
      ST_CLAMP: begin
        c.upd_integ = 1'b1;
        c.emit      = 1'b1;
        c.done      = 1'b1;
      end
      ST_GOAL: begin
        c.set_goal = 1'b1;
        c.done     = 1'b1;
      end
      default: c.done = 1'b1;
    endcase
    return c;
  endfunction

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  ctrl_t             word;
  logic              stall;
  logic              take;

  assign word   = rom(step_q);
  assign stall  = word.emit && out_full_i;
  assign ctrl_o = (busy_q && !stall) ? word : CTRL_NOP;
  assign busy_o = busy_q;

  // branch condition
  always_comb begin
    case (word.jmp)
      JMP_NONE:     take = 1'b0;
      JMP_ALWAYS:   take = 1'b1;
      JMP_GOAL:     take = status_i.is_goal;
      JMP_SAT:      take = status_i.sat;
      JMP_NO_DECAY: take = status_i.no_decay;
      default:      take = 1'b0;
    endcase
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= ST_START;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= ST_START;
    end else if (busy_q && !stall) begin
      if (word.done) begin
        busy_q <= 1'b0;
      end else if (take) begin
        step_q <= word.target;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

endmodule

>>> src/psr_datapath.sv
// psr_datapath: registers, shared multiplier and adder of the PI speed regulator
// holds configuration, goal, integrator and the drive result
// depends on psr_pkg
module psr_datapath import psr_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  input  logic                         in_load_i,
  input  logic                         in_op_i,
  input  logic signed [DATA_WIDTH-1:0] in_speed_i,
  input  ctrl_t                        ctrl_i,
  output status_t                      status_o,
  output logic signed [DATA_WIDTH-1:0] drive_o,
  output logic                         sat_o
);

  localparam int unsigned SW  = DATA_WIDTH + 27;
  localparam int unsigned EW  = DATA_WIDTH + 1;
  localparam int unsigned CW  = 33;

  // configuration
  logic [GAIN_W-1:0] kp_q, ki_q;
  logic [LIM_W-1:0]  dlim_q, glim_q, dband_q;

  // item and working registers
  logic                         op_q;
  logic signed [DATA_WIDTH-1:0] speed_q;
  logic signed [DATA_WIDTH-1:0] goal_q;
  logic signed [INTEG_W-1:0]    integ_q;
  logic signed [EW-1:0]         err_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [SW-1:0]         sum_q;
  logic                         sign_q;
  logic signed [DATA_WIDTH-1:0] drive_q;
  logic                         sat_q;

  logic signed [SW-1:0]         dlim_ext, dlim_neg;
  logic                         sat_hi, sat_lo;
  logic                         sum_neg;
  logic [SW-1:0]                sum_abs;
  logic [MAG_W-1:0]             mag;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic [EW-1:0]                err_abs;
  logic signed [EW-1:0]         err_d;
  logic [MAG_W-1:0]             dec;
  logic signed [SW-1:0]         sum_d;
  logic signed [CW-1:0]         v_w, glim_w, goal_w;
  logic signed [INTEG_W-1:0]    integ_clamp;
  logic signed [DATA_WIDTH-1:0] drive_d;

  // limit in Q.16 and clamp tests on the running sum
  assign dlim_ext = $signed({{(SW-LIM_W-FRAC_W){1'b0}}, dlim_q, {FRAC_W{1'b0}}});
  assign dlim_neg = -dlim_ext;
  assign sat_hi   = sum_q > dlim_ext;
  assign sat_lo   = sum_q < dlim_neg;

  // capped magnitude for the decay multiply
  assign sum_neg = sum_q[SW-1];
  assign sum_abs = sum_neg ? (~sum_q + 1'b1) : sum_q;
  assign mag     = (sum_abs > SW'(MAG_CAP)) ? MAG_CAP : sum_abs[MAG_W-1:0];

  // error and its magnitude
  assign err_d   = $signed({goal_q[DATA_WIDTH-1], goal_q})
                 - $signed({speed_q[DATA_WIDTH-1], speed_q});
  assign err_abs = err_q[EW-1] ? (~err_q + 1'b1) : err_q;

  // multiplier operand selection
  always_comb begin
    mul_a = $signed({{(MUL_A_W-EW){err_q[EW-1]}}, err_q});
    mul_b = $signed({1'b0, kp_q});
    case (ctrl_i.mul_op)
      MUL_KP: mul_b = $signed({1'b0, kp_q});
      MUL_KI: mul_b = $signed({1'b0, ki_q});
      MUL_DECAY: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({{(MUL_B_W-KDEC_W){1'b0}},
                         (sat_q ? K_DECAY_CLAMPED : K_DECAY_DEADBAND)});
      end
      default: ;
    endcase
  end

  // adder input selection
  assign dec = prod_q[FRAC_W+MAG_W-1:FRAC_W];
  always_comb begin
    case (ctrl_i.sum_op)
      SUM_PROD_INTEG: sum_d = prod_q[SW-1:0]
                            + $signed({{(SW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q});
      SUM_INTEG:      sum_d = $signed({{(SW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q});
      SUM_DECAY:      sum_d = sign_q ? -$signed({{(SW-MAG_W){1'b0}}, dec})
                                     :  $signed({{(SW-MAG_W){1'b0}}, dec});
      default:        sum_d = sum_q;
    endcase
  end

  // drive, floored to an integer, or clamped
  always_comb begin
    if (sat_hi)      drive_d = dlim_ext[DATA_WIDTH+FRAC_W-1:FRAC_W];
    else if (sat_lo) drive_d = dlim_neg[DATA_WIDTH+FRAC_W-1:FRAC_W];
    else             drive_d = sum_q[DATA_WIDTH+FRAC_W-1:FRAC_W];
  end

  // integrator clamp
  always_comb begin
    if (sat_hi)      integ_clamp = dlim_ext[INTEG_W-1:0];
    else if (sat_lo) integ_clamp = dlim_neg[INTEG_W-1:0];
    else             integ_clamp = sum_q[INTEG_W-1:0];
  end

  // goal clamp
  assign v_w    = $signed({{(CW-DATA_WIDTH){speed_q[DATA_WIDTH-1]}}, speed_q});
  assign glim_w = $signed({{(CW-LIM_W){1'b0}}, glim_q});
  always_comb begin
    if (v_w > glim_w)       goal_w = glim_w;
    else if (v_w < -glim_w) goal_w = -glim_w;
    else                    goal_w = v_w;
  end

  assign status_o.is_goal  = !op_q;
  assign status_o.sat      = sat_hi || sat_lo;
  assign status_o.no_decay = !(CW'(err_abs) < CW'(dband_q));

  assign drive_o = drive_q;
  assign sat_o   = sat_q;

  // configuration, goal and integrator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      dlim_q  <= '1;
      glim_q  <= '1;
      dband_q <= '0;
      goal_q  <= '0;
      integ_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROP_GAIN: begin
            kp_q    <= cfg_data_i;
            integ_q <= '0;
          end
          REG_INTEG_GAIN: begin
            ki_q    <= cfg_data_i;
            integ_q <= '0;
          end
          REG_DRIVE_LIMIT: dlim_q  <= cfg_data_i[LIM_W-1:0];
          REG_GOAL_LIMIT:  glim_q  <= cfg_data_i[LIM_W-1:0];
          REG_DEADBAND:    dband_q <= cfg_data_i[LIM_W-1:0];
          default: ;
        endcase
      end
      if (ctrl_i.set_goal) begin
        goal_q <= goal_w[DATA_WIDTH-1:0];
        if (goal_w == '0) integ_q <= '0;
      end
      if (ctrl_i.upd_integ) integ_q <= integ_clamp;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      op_q    <= in_op_i;
      speed_q <= in_speed_i;
    end
    if (ctrl_i.ld_err) err_q <= err_d;
    if (ctrl_i.mul_op != MUL_NONE) prod_q <= mul_a * mul_b;
    if (ctrl_i.mul_op == MUL_DECAY) sign_q <= sum_neg;
    sum_q <= sum_d;
    if (ctrl_i.eval_drive) begin
      drive_q <= drive_d;
      sat_q   <= sat_hi || sat_lo;
    end
  end

endmodule

>>> src/pi_speed_regulator_antiwindup_top.sv
// Sample item: 7 sequencer steps on the shared multiplier, 8 when the drive clamps,
// 9 when the deadband decay runs. Set-goal item: 2 steps, no result. One item at a
// time: the next item is taken in the cycle after the last step, even while a result
// waits; only a full output register stalls the last step of a sample.
// Reset clears gains, goal and integrator; both limits go to 32767.
// pi_speed_regulator_antiwindup_top: stream ports, output register, sequencer and datapath
// depends on psr_pkg, psr_sequencer, psr_datapath
module pi_speed_regulator_antiwindup_top import psr_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [CFG_W-1:0]                    cfg_data_i,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // speed_value
  input  logic                                s_axis_tuser,  // opcode
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // drive
  output logic                                m_axis_tuser   // saturated
);

  localparam int unsigned TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  ctrl_t                        ctrl;
  status_t                      status;
  logic                         busy;
  logic                         accept;
  logic signed [DATA_WIDTH-1:0] drive;
  logic                         sat;
  logic                         out_valid_q;
  logic [DATA_WIDTH-1:0]        out_drive_q;
  logic                         out_sat_q;
  logic                         out_full;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  assign out_full      = out_valid_q && !m_axis_tready;

  psr_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .out_full_i (out_full),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  psr_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_load_i  (accept),
    .in_op_i    (s_axis_tuser),
    .in_speed_i ($signed(s_axis_tdata[DATA_WIDTH-1:0])),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .drive_o    (drive),
    .sat_o      (sat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_drive_q <= drive;
      out_sat_q   <= sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TDATA_W-DATA_WIDTH){1'b0}}, out_drive_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

>>> sim/pi_speed_regulator_antiwindup_top_tb.sv
// pi_speed_regulator_antiwindup_top_tb: self-checking bench for the PI speed regulator
// runs a directed plan, then random goal and sample items, predicting every drive item
// depends on psr_pkg and pi_speed_regulator_antiwindup_top
module pi_speed_regulator_antiwindup_top_tb;
  import psr_pkg::*;

  localparam int unsigned DW          = 16;
  localparam int unsigned BUS_W       = ((DW+7)/8)*8;
  localparam logic        OP_SET_GOAL = 1'b0;
  localparam logic        OP_SAMPLE   = 1'b1;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int unsigned SETTLE_CYC  = 16;
  localparam int unsigned PHASES      = 22;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned HOLD_CYC    = 300;
  localparam int unsigned TIMEOUT_CYC = 300000;
  localparam int unsigned PLAN_LEN    = 38;

  // clock, reset and block inputs, all known from time zero
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [BUS_W-1:0] s_axis_tdata  = '0;  // speed_value
  logic             s_axis_tuser  = 1'b0; // opcode
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [BUS_W-1:0] m_axis_tdata;        // drive
  logic             m_axis_tuser;        // saturated

  always #6 clk_i = ~clk_i;

  pi_speed_regulator_antiwindup_top #(
    .DATA_WIDTH(DW)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 sat;
  } drive_res_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_GOAL, ROW_SAMPLE} row_kind_e;

  // one step of the directed plan; value is register data or speed
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    int                   value;
    logic                 typed;
    logic signed [DW-1:0] drv;
    logic                 sat;
  } plan_row_t;

  // regulator state as the bench sees it
  logic [GAIN_W-1:0] kp_r        = '0;
  logic [GAIN_W-1:0] ki_r        = '0;
  logic [LIM_W-1:0]  drive_lim_r = '1;
  logic [LIM_W-1:0]  goal_lim_r  = '1;
  logic [LIM_W-1:0]  deadband_r  = '0;
  longint            integ_q     = 0;
  longint            goal_q      = 0;

  drive_res_t  drive_expect_q [$];
  int          mismatch_cnt  = 0;
  int unsigned src_idle_max  = 0;
  int unsigned sink_idle_max = 0;
  int unsigned hold_cycles   = 0;

  plan_row_t plan [PLAN_LEN] = '{
    // reset gains give zero drive at the speed extremes
    '{ROW_SAMPLE, REG_PROP_GAIN,   0,        1'b1, 16'sd0,      1'b0},
    '{ROW_GOAL,   REG_PROP_GAIN,   32767,    1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   -32768,   1'b1, 16'sd0,      1'b0},
    '{ROW_GOAL,   REG_PROP_GAIN,   -32768,   1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   32767,    1'b1, 16'sd0,      1'b0},
    // largest proportional gain, then clamping at the full limit
    '{ROW_WRITE,  REG_PROP_GAIN,   16777215, 1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   -32768,   1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   32767,    1'b1, -16'sd32767, 1'b1},
    // zero drive limit forces zero drive
    '{ROW_WRITE,  REG_DRIVE_LIMIT, 0,        1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   -32767,   1'b1, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   0,        1'b1, 16'sd0,      1'b1},
    // unit kp, small ki, widest deadband: decay near the goal
    '{ROW_WRITE,  REG_DRIVE_LIMIT, 32767,    1'b0, 16'sd0,      1'b0},
    '{ROW_WRITE,  REG_PROP_GAIN,   65536,    1'b0, 16'sd0,      1'b0},
    '{ROW_WRITE,  REG_INTEG_GAIN,  6554,     1'b0, 16'sd0,      1'b0},
    '{ROW_WRITE,  REG_DEADBAND,    32767,    1'b0, 16'sd0,      1'b0},
    '{ROW_GOAL,   REG_PROP_GAIN,   1000,     1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   900,      1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   1000,     1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   1100,     1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   1250,     1'b0, 16'sd0,      1'b0},
    // zero goal clears the integrator
    '{ROW_GOAL,   REG_PROP_GAIN,   0,        1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   5,        1'b0, 16'sd0,      1'b0},
    // zero goal limit forces a zero goal
    '{ROW_WRITE,  REG_GOAL_LIMIT,  0,        1'b0, 16'sd0,      1'b0},
    '{ROW_GOAL,   REG_PROP_GAIN,   12345,    1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   -3,       1'b0, 16'sd0,      1'b0},
    // largest integration step; drive equal to the limit is not clamped
    '{ROW_WRITE,  REG_GOAL_LIMIT,  32767,    1'b0, 16'sd0,      1'b0},
    '{ROW_WRITE,  REG_DEADBAND,    0,        1'b0, 16'sd0,      1'b0},
    '{ROW_WRITE,  REG_PROP_GAIN,   0,        1'b0, 16'sd0,      1'b0},
    '{ROW_WRITE,  REG_INTEG_GAIN,  16777215, 1'b0, 16'sd0,      1'b0},
    '{ROW_GOAL,   REG_PROP_GAIN,   32767,    1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   -32768,   1'b1, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   -32768,   1'b1, 16'sd32767,  1'b0},
    // write to an unused index changes nothing
    '{ROW_WRITE,  REG_SPARE,       12345,    1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   32767,    1'b0, 16'sd0,      1'b0},
    // limit of one with a full integrator
    '{ROW_WRITE,  REG_DRIVE_LIMIT, 1,        1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   -32768,   1'b1, 16'sd1,      1'b1},
    '{ROW_SAMPLE, REG_PROP_GAIN,   0,        1'b0, 16'sd0,      1'b0},
    '{ROW_SAMPLE, REG_PROP_GAIN,   -32768,   1'b0, 16'sd0,      1'b0}
  };

  // magnitude times a Q0.16 factor, truncated toward zero
  function automatic longint shrink_toward_zero(longint x, longint k);
    longint cap;
    longint v;
    longint mag;
    cap = longint'(1) << 40;
    v = x;
    if (v > cap) v = cap;
    if (v < -cap) v = -cap;
    mag = (v < 0) ? -v : v;
    mag = (mag * k) >>> 16;
    return (v < 0) ? -mag : mag;
  endfunction

  // drive for one measured speed, advances the integrator
  function automatic drive_res_t predict_sample(logic signed [DW-1:0] meas);
    longint     lim_q;
    longint     err;
    longint     sum;
    longint     drv;
    longint     nxt;
    longint     aerr;
    drive_res_t res;
    lim_q = longint'(drive_lim_r) * 65536;
    err = goal_q - longint'(meas);
    sum = err * longint'(kp_r) + integ_q;
    res.sat = 1'b1;
    if (sum > lim_q) drv = longint'(drive_lim_r);
    else if (sum < -lim_q) drv = -longint'(drive_lim_r);
    else begin
      res.sat = 1'b0;
      drv = sum >>> 16;
    end
    res.drive = drv[DW-1:0];
    // anti-windup: decay when clamped, else integrate with deadband decay
    if (res.sat) begin
      nxt = shrink_toward_zero(integ_q, longint'(K_DECAY_CLAMPED));
    end else begin
      nxt = integ_q + err * longint'(ki_r);
      aerr = (err < 0) ? -err : err;
      if (aerr < longint'(deadband_r))
        nxt = shrink_toward_zero(nxt, longint'(K_DECAY_DEADBAND));
    end
    if (nxt > lim_q) nxt = lim_q;
    else if (nxt < -lim_q) nxt = -lim_q;
    integ_q = nxt;
    return res;
  endfunction

  // offer one item after a random gap; predict on acceptance
  task automatic send_item(logic op, logic [DW-1:0] val, logic typed, drive_res_t typed_res);
    int unsigned gap;
    longint      g;
    drive_res_t  res;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_SET_GOAL) begin
      g = longint'($signed(val));
      if (g > longint'(goal_lim_r)) g = longint'(goal_lim_r);
      if (g < -longint'(goal_lim_r)) g = -longint'(goal_lim_r);
      if (g == 0) integ_q = 0;
      goal_q = g;
    end else begin
      res = predict_sample(val);
      drive_expect_q.push_back(typed ? typed_res : res);
    end
    @(negedge clk_i);
  endtask

  // stop offering, wait for all drive items, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (drive_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_PROP_GAIN: begin
        kp_r = val[GAIN_W-1:0];
        integ_q = 0;
      end
      REG_INTEG_GAIN: begin
        ki_r = val[GAIN_W-1:0];
        integ_q = 0;
      end
      REG_DRIVE_LIMIT: drive_lim_r = val[LIM_W-1:0];
      REG_GOAL_LIMIT:  goal_lim_r = val[LIM_W-1:0];
      REG_DEADBAND:    deadband_r = val[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver: random stalls, one long hold on request, checks each drive item
  initial begin
    int unsigned stall;
    drive_res_t  want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, sink_idle_max);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (drive_expect_q.size() == 0) begin
        $display("%0t: drive item with none pending, expected none actual %0d", $time,
                 $signed(m_axis_tdata[DW-1:0]));
        mismatch_cnt++;
      end else begin
        want = drive_expect_q.pop_front();
        if (m_axis_tdata[DW-1:0] !== want.drive) begin
          $display("%0t: drive expected %0d actual %0d", $time, want.drive,
                   $signed(m_axis_tdata[DW-1:0]));
          mismatch_cnt++;
        end
        if (m_axis_tuser !== want.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, want.sat, m_axis_tuser);
          mismatch_cnt++;
        end
      end
      @(negedge clk_i);
    end
  end

  // main sequence
  initial begin
    drive_res_t       none;
    drive_res_t       want;
    logic [DW-1:0]    sv;
    logic [CFG_W-1:0] w;
    none = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed plan, random gaps on both sides
    src_idle_max  = 14;
    sink_idle_max = 14;
    for (int i = 0; i < PLAN_LEN; i++) begin
      want.drive = plan[i].drv;
      want.sat   = plan[i].sat;
      case (plan[i].kind)
        ROW_WRITE:  write_reg(plan[i].idx, plan[i].value[CFG_W-1:0]);
        ROW_GOAL:   send_item(OP_SET_GOAL, plan[i].value[DW-1:0], 1'b0, none);
        default:    send_item(OP_SAMPLE, plan[i].value[DW-1:0], plan[i].typed, want);
      endcase
    end

    // random phases, each rewriting a random choice of settings
    for (int ph = 0; ph < PHASES; ph++) begin
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = 24'hFF_FFFF;
          default: w = CFG_W'($urandom_range(0, 262143));
        endcase
        write_reg(REG_PROP_GAIN, w);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = 24'hFF_FFFF;
          default: w = CFG_W'($urandom_range(0, 32768));
        endcase
        write_reg(REG_INTEG_GAIN, w);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0:       w = '0;
          1:       w = 24'd32767;
          2:       w = CFG_W'($urandom_range(1, 200));
          default: w = CFG_W'($urandom_range(1, 32767));
        endcase
        write_reg(REG_DRIVE_LIMIT, w);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = 24'd32767;
          default: w = CFG_W'($urandom_range(1, 32767));
        endcase
        write_reg(REG_GOAL_LIMIT, w);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = 24'd32767;
          default: w = CFG_W'($urandom_range(0, 2000));
        endcase
        write_reg(REG_DEADBAND, w);
      end

      // idle pattern of this phase, some with no gaps at all
      case ($urandom_range(0, 3))
        0: begin
          src_idle_max  = 0;
          sink_idle_max = 0;
        end
        1: begin
          src_idle_max  = 14;
          sink_idle_max = 14;
        end
        2: begin
          src_idle_max  = 3;
          sink_idle_max = 14;
        end
        default: begin
          src_idle_max  = 14;
          sink_idle_max = 2;
        end
      endcase
      // back-pressure: receiver holds off while items keep coming
      if (ph == 2) begin
        hold_cycles  = HOLD_CYC;
        src_idle_max = 0;
      end

      // mostly samples near the goal, some goal changes and full-range noise
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 12) begin
          if ($urandom_range(0, 2) == 0) sv = 16'($urandom);
          else sv = 16'($urandom_range(0, 8000) - 4000);
          send_item(OP_SET_GOAL, sv, 1'b0, none);
        end else begin
          if ($urandom_range(0, 9) < 7) sv = 16'(goal_q + longint'($urandom_range(0, 4000)) - 2000);
          else sv = 16'($urandom);
          send_item(OP_SAMPLE, sv, 1'b0, none);
        end
      end
    end

    settle();
    if (mismatch_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // run limit
  initial begin
    #(12 * TIMEOUT_CYC);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
